### hw/rtl/ascl_pkg.sv
// Shared types, constants and segment tables for the converter scaling block.
package ascl_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int KIND_W      = 3;
    localparam int GAIN_W      = 16;
    localparam int OUT_W       = 22;
    localparam int CFG_IDX_W   = 3;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // divide by 100: multiply by ceil(2^37/100), exact for any 32-bit product
    localparam int             PROD_W        = SAMPLE_BITS + GAIN_W;
    localparam int             DIV100_MAG_W  = 31;
    localparam logic [DIV100_MAG_W-1:0] DIV100_MAGIC = 31'd1374389535;
    localparam int             DIV100_SHIFT  = 37;
    localparam int             MPROD_W       = PROD_W + DIV100_MAG_W;
    localparam int             QUOT_W        = MPROD_W - DIV100_SHIFT;

    // current linearization
    localparam int LIN_X_W   = 12;
    localparam int SEG_COUNT = 15;
    localparam int SEG_W     = 4;
    localparam int D_W       = 9;
    localparam int STEP_W    = 13;
    localparam int NUM_W     = 21;
    localparam int LMAG_W    = 29;
    localparam int LSHIFT    = 32;
    localparam int LPROD_W   = NUM_W + LMAG_W;
    localparam int LVAL_W    = 16;

    localparam logic [LIN_X_W-1:0] LIN_LOW  = 12'd15;
    localparam logic [LIN_X_W-1:0] LIN_HIGH = 12'd3403;
    localparam logic [LVAL_W-1:0]  LIN_SAT  = 16'd50000;

    localparam logic [KIND_W-1:0] CH_BATTERY     = 3'd0;
    localparam logic [KIND_W-1:0] CH_CURRENT     = 3'd1;
    localparam logic [KIND_W-1:0] CH_POWER_GOOD  = 3'd2;
    localparam logic [KIND_W-1:0] CH_CHARGER_OUT = 3'd3;
    localparam logic [KIND_W-1:0] CH_INPUT_VOLT  = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_BATTERY_RST     = 16'd1410;
    localparam logic [GAIN_W-1:0] GAIN_CURRENT_RST     = 16'd1000;
    localparam logic [GAIN_W-1:0] GAIN_POWER_GOOD_RST  = 16'd1000;
    localparam logic [GAIN_W-1:0] GAIN_CHARGER_OUT_RST = 16'd1110;
    localparam logic [GAIN_W-1:0] GAIN_INPUT_VOLT_RST  = 16'd5590;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_BATTERY     = 3'd0,
        REG_GAIN_CURRENT     = 3'd1,
        REG_GAIN_POWER_GOOD  = 3'd2,
        REG_GAIN_CHARGER_OUT = 3'd3,
        REG_GAIN_INPUT_VOLT  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        LIN_ZERO,
        LIN_SEG,
        LIN_FULL
    } t_lin_mode;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [SAMPLE_BITS-1:0] sample;
    } t_ascl_in;

    typedef struct packed {
        logic [KIND_W-1:0] out_channel;
        logic [OUT_W-1:0]  scaled_value;
    } t_ascl_out;

    // item handed from the scaling stages to the linearizer
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [QUOT_W-1:0] value;
    } t_ascl_mid;

    function automatic logic [LIN_X_W-1:0] seg_upper(input logic [SEG_W-1:0] idx);
        logic [LIN_X_W-1:0] v;
        case (idx)
            4'd0:    v = 12'd110;
            4'd1:    v = 12'd124;
            4'd2:    v = 12'd137;
            4'd3:    v = 12'd151;
            4'd4:    v = 12'd164;
            4'd5:    v = 12'd427;
            4'd6:    v = 12'd758;
            4'd7:    v = 12'd1089;
            4'd8:    v = 12'd1420;
            4'd9:    v = 12'd1750;
            4'd10:   v = 12'd2081;
            4'd11:   v = 12'd2412;
            4'd12:   v = 12'd2742;
            4'd13:   v = 12'd3073;
            default: v = 12'd3403;
        endcase
        return v;
    endfunction

    function automatic logic [LIN_X_W-1:0] seg_start(input logic [SEG_W-1:0] idx);
        logic [LIN_X_W-1:0] v;
        case (idx)
            4'd0:    v = 12'd15;
            4'd1:    v = 12'd110;
            4'd2:    v = 12'd124;
            4'd3:    v = 12'd137;
            4'd4:    v = 12'd151;
            4'd5:    v = 12'd164;
            4'd6:    v = 12'd427;
            4'd7:    v = 12'd758;
            4'd8:    v = 12'd1089;
            4'd9:    v = 12'd1420;
            4'd10:   v = 12'd1750;
            4'd11:   v = 12'd2081;
            4'd12:   v = 12'd2412;
            4'd13:   v = 12'd2742;
            default: v = 12'd3073;
        endcase
        return v;
    endfunction

    function automatic logic [LVAL_W-1:0] seg_base(input logic [SEG_W-1:0] idx);
        logic [LVAL_W-1:0] v;
        case (idx)
            4'd0:    v = 16'd0;
            4'd1:    v = 16'd200;
            4'd2:    v = 16'd400;
            4'd3:    v = 16'd600;
            4'd4:    v = 16'd800;
            4'd5:    v = 16'd1000;
            4'd6:    v = 16'd5000;
            4'd7:    v = 16'd10000;
            4'd8:    v = 16'd15000;
            4'd9:    v = 16'd20000;
            4'd10:   v = 16'd25000;
            4'd11:   v = 16'd30000;
            4'd12:   v = 16'd35000;
            4'd13:   v = 16'd40000;
            default: v = 16'd45000;
        endcase
        return v;
    endfunction

    function automatic logic [STEP_W-1:0] seg_step(input logic [SEG_W-1:0] idx);
        logic [STEP_W-1:0] v;
        if (idx <= 4'd5) begin
            v = 13'd200;
        end else if (idx == 4'd6) begin
            v = 13'd4000;
        end else begin
            v = 13'd5000;
        end
        return v;
    endfunction

    // ceil(2^32 / width): exact quotient for numerators below 2^21
    function automatic logic [LMAG_W-1:0] seg_magic(input logic [SEG_W-1:0] idx);
        logic [LMAG_W-1:0] v;
        case (idx)
            4'd0:                 v = 29'd45210183;   // width 95
            4'd1, 4'd3:           v = 29'd306783379;  // width 14
            4'd2, 4'd4:           v = 29'd330382100;  // width 13
            4'd5:                 v = 29'd16330675;   // width 263
            4'd9, 4'd12, 4'd14:   v = 29'd13015053;   // width 330
            default:              v = 29'd12975733;   // width 331
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/adc_scale_and_current_linearize.sv
// Top level: per-channel gain scaling, divide by 100, current linearization.
//
//  channel  direction  handshake                   payload
//  in       request    i_in_valid / o_in_ready     i_in_data  (kind, sample)
//  out      result     o_out_valid / i_out_ready   o_out_data (out_channel, scaled_value)
//  cfg      write      i_cfg_wr_en                 i_cfg_idx, i_cfg_wdata
//
// One request per cycle while the output is not stalled; six register stages
// (gain multiply, reciprocal multiply for /100, segment search, step multiply,
// reciprocal multiply for the segment width, output register).
// Synchronous active-low reset clears valid bits and loads the gain defaults.
// A stalled output freezes every stage; nothing is dropped or repeated.
module adc_scale_and_current_linearize (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ascl_pkg::t_ascl_in                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ascl_pkg::t_ascl_out               o_out_data,
    input  logic                              i_cfg_wr_en,
    input  logic [ascl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ascl_pkg::GAIN_W-1:0]       i_cfg_wdata
);
    import ascl_pkg::*;

    logic [GAIN_W-1:0]  r_gain_battery;
    logic [GAIN_W-1:0]  r_gain_current;
    logic [GAIN_W-1:0]  r_gain_power_good;
    logic [GAIN_W-1:0]  r_gain_charger_out;
    logic [GAIN_W-1:0]  r_gain_input_volt;

    logic               adv;
    logic [GAIN_W-1:0]  gain;

    logic               r1_valid;
    logic [KIND_W-1:0]  r1_kind;
    logic [PROD_W-1:0]  r1_prod;
    logic               r2_valid;
    logic [KIND_W-1:0]  r2_kind;
    logic [MPROD_W-1:0] r2_mprod;

    t_ascl_mid          mid;
    logic               out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_battery     <= GAIN_BATTERY_RST;
            r_gain_current     <= GAIN_CURRENT_RST;
            r_gain_power_good  <= GAIN_POWER_GOOD_RST;
            r_gain_charger_out <= GAIN_CHARGER_OUT_RST;
            r_gain_input_volt  <= GAIN_INPUT_VOLT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_GAIN_BATTERY:     r_gain_battery     <= i_cfg_wdata;
                REG_GAIN_CURRENT:     r_gain_current     <= i_cfg_wdata;
                REG_GAIN_POWER_GOOD:  r_gain_power_good  <= i_cfg_wdata;
                REG_GAIN_CHARGER_OUT: r_gain_charger_out <= i_cfg_wdata;
                REG_GAIN_INPUT_VOLT:  r_gain_input_volt  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_in_data.kind)
            CH_BATTERY:     gain = r_gain_battery;
            CH_CURRENT:     gain = r_gain_current;
            CH_POWER_GOOD:  gain = r_gain_power_good;
            CH_CHARGER_OUT: gain = r_gain_charger_out;
            CH_INPUT_VOLT:  gain = r_gain_input_volt;
            default:        gain = '0;  // unused channel codes scale to zero
        endcase
    end

    assign adv        = !out_valid || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= i_in_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_kind  <= i_in_data.kind;
            r1_prod  <= PROD_W'(i_in_data.sample) * PROD_W'(gain);
            r2_kind  <= r1_kind;
            r2_mprod <= MPROD_W'(r1_prod) * MPROD_W'(DIV100_MAGIC);
        end
    end

    always_comb begin
        mid.valid = r2_valid;
        mid.kind  = r2_kind;
        mid.value = r2_mprod[DIV100_SHIFT +: QUOT_W];
    end

    ascl_lin u_lin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_mid   (mid),
        .o_valid (out_valid),
        .o_data  (o_out_data)
    );

    assign o_out_valid = out_valid;

endmodule

### hw/rtl/ascl_lin.sv
// Back half of the pipeline: current-channel linearization and output register.
module ascl_lin (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  ascl_pkg::t_ascl_mid   i_mid,
    output logic                  o_valid,
    output ascl_pkg::t_ascl_out   o_data
);
    import ascl_pkg::*;

    localparam int QX_W = (QUOT_W > OUT_W) ? QUOT_W : OUT_W;

    logic [QX_W-1:0]    q_ext;
    logic [OUT_W-1:0]   pass_val;
    logic [LIN_X_W-1:0] x_lo;
    logic               below;
    logic               above;
    logic [SEG_W-1:0]   seg;
    t_lin_mode          mode;

    // stage 1: segment search
    logic               r1_valid;
    logic [KIND_W-1:0]  r1_kind;
    logic               r1_cur;
    t_lin_mode          r1_mode;
    logic [SEG_W-1:0]   r1_seg;
    logic [D_W-1:0]     r1_d;
    logic [OUT_W-1:0]   r1_pass;
    // stage 2: step * offset
    logic               r2_valid;
    logic [KIND_W-1:0]  r2_kind;
    logic               r2_cur;
    t_lin_mode          r2_mode;
    logic [SEG_W-1:0]   r2_seg;
    logic [NUM_W-1:0]   r2_num;
    logic [OUT_W-1:0]   r2_pass;
    // stage 3: reciprocal multiply
    logic               r3_valid;
    logic [KIND_W-1:0]  r3_kind;
    logic               r3_cur;
    t_lin_mode          r3_mode;
    logic [SEG_W-1:0]   r3_seg;
    logic [LPROD_W-1:0] r3_prod;
    logic [OUT_W-1:0]   r3_pass;
    // stage 4: output
    logic               r_out_valid;
    t_ascl_out          r_out;
    t_ascl_out          n_out;

    logic [STEP_W-1:0]  seg_quot;
    logic [LVAL_W-1:0]  lin_val;

    always_comb begin
        q_ext    = QX_W'(i_mid.value);
        pass_val = (q_ext > QX_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(q_ext);
        below    = (q_ext < QX_W'(LIN_LOW));
        above    = (q_ext > QX_W'(LIN_HIGH));
        x_lo     = i_mid.value[LIN_X_W-1:0];
        seg      = SEG_W'(SEG_COUNT - 1);
        for (int i = SEG_COUNT - 1; i >= 0; i--) begin
            if (x_lo <= seg_upper(SEG_W'(i))) begin
                seg = SEG_W'(i);
            end
        end
        if (below) begin
            mode = LIN_ZERO;
        end else if (above) begin
            mode = LIN_FULL;
        end else begin
            mode = LIN_SEG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_mid.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_kind <= i_mid.kind;
            r1_cur  <= (i_mid.kind == CH_CURRENT);
            r1_mode <= mode;
            r1_seg  <= seg;
            r1_d    <= D_W'(x_lo - seg_start(seg));
            r1_pass <= pass_val;

            r2_kind <= r1_kind;
            r2_cur  <= r1_cur;
            r2_mode <= r1_mode;
            r2_seg  <= r1_seg;
            r2_num  <= NUM_W'(NUM_W'(seg_step(r1_seg)) * NUM_W'(r1_d));
            r2_pass <= r1_pass;

            r3_kind <= r2_kind;
            r3_cur  <= r2_cur;
            r3_mode <= r2_mode;
            r3_seg  <= r2_seg;
            r3_prod <= LPROD_W'(r2_num) * LPROD_W'(seg_magic(r2_seg));
            r3_pass <= r2_pass;
        end
    end

    always_comb begin
        seg_quot = r3_prod[LSHIFT +: STEP_W];
        case (r3_mode)
            LIN_ZERO: lin_val = '0;
            LIN_FULL: lin_val = LIN_SAT;
            default:  lin_val = seg_base(r3_seg) + LVAL_W'(seg_quot);
        endcase
        n_out.out_channel  = r3_kind;
        n_out.scaled_value = r3_cur ? OUT_W'(lin_val) : r3_pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
